// File: src/flow_steer_tx_queue_select_core_defines.svh
// -----------------------------------------------------------------------------
// Transmit queue steering: assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// -----------------------------------------------------------------------------
`ifndef FLOW_STEER_TX_QUEUE_SELECT_CORE_DEFINES_SVH
`define FLOW_STEER_TX_QUEUE_SELECT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked on clk, muted while rst_n is low
`define FSQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// clocked on clk, checked during reset as well
`define FSQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define FSQ_ASSERT(label, prop, msg)
`define FSQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: src/fsq_pkg.sv
// -----------------------------------------------------------------------------
// fsq_pkg
// Shared types and constants of the transmit queue steering block.
// -----------------------------------------------------------------------------
package fsq_pkg;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // command queue between classifier and matcher
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_LOOKUP   = 2'd0,
        MODE_SET_ADDR = 2'd1,
        MODE_SET_PORT = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_EXACT     = 3'd1,
        KIND_IP_ONLY   = 3'd2,
        KIND_PORT_ONLY = 3'd3,
        KIND_DEV_ERROR = 3'd4
    } match_kind_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_LOOKUP,
        CMD_DEV_ERR,
        CMD_SET_ADDR,
        CMD_SET_PORT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [5:0]  queue;
        logic [31:0] addr;
        logic [15:0] port;
    } cmd_t;

endpackage

// File: src/fsq_ifs.sv
// -----------------------------------------------------------------------------
// fsq stream interfaces
// Valid/ready channels for request words and result words.
// -----------------------------------------------------------------------------
interface fsq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [5:0]  target_queue;
    logic [31:0] addr_value;
    logic [15:0] port_value;
    logic [15:0] ethertype;
    logic [7:0]  l4_protocol;

    modport source (
        output valid, mode, target_queue, addr_value, port_value, ethertype, l4_protocol,
        input  ready
    );
    modport sink (
        input  valid, mode, target_queue, addr_value, port_value, ethertype, l4_protocol,
        output ready
    );
endinterface

interface fsq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  match_kind;
    logic [5:0]  chosen_queue;
    logic [31:0] stored_addr;
    logic [15:0] stored_port;

    modport source (
        output valid, match_kind, chosen_queue, stored_addr, stored_port,
        input  ready
    );
    modport sink (
        input  valid, match_kind, chosen_queue, stored_addr, stored_port,
        output ready
    );
endinterface

// File: src/fsq_front.sv
// -----------------------------------------------------------------------------
// fsq_front
// Accepts request words, holds the device error flag and classifies each
// word into a command for the matcher.
// -----------------------------------------------------------------------------
module fsq_front
    import fsq_pkg::*;
#(
    parameter int NUM_QUEUES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    fsq_in_if.sink       in_ch,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         full,
    output logic         push,
    output cmd_t         push_cmd
);

    logic dev_err_reg;
    logic eligible;
    logic in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_err_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            dev_err_reg <= cfg_wdata;
        end
    end

    assign in_ch.ready = !full;
    assign push        = in_ch.valid && !full;

    assign eligible = (in_ch.ethertype == ETYPE_IPV4) &&
                      ((in_ch.l4_protocol == PROTO_TCP) || (in_ch.l4_protocol == PROTO_UDP));
    assign in_range = {3'b000, in_ch.target_queue} < 9'(NUM_QUEUES);

    always_comb
    begin
        push_cmd.queue = in_ch.target_queue;
        push_cmd.addr  = in_ch.addr_value;
        push_cmd.port  = in_ch.port_value;
        push_cmd.kind  = CMD_NOP;
        unique case (mode_t'(in_ch.mode))
            MODE_LOOKUP:
            begin
                if (dev_err_reg)
                    push_cmd.kind = CMD_DEV_ERR;
                else if (eligible)
                    push_cmd.kind = CMD_LOOKUP;
                else
                    push_cmd.kind = CMD_NOP;
            end
            MODE_SET_ADDR: push_cmd.kind = in_range ? CMD_SET_ADDR : CMD_NOP;
            MODE_SET_PORT: push_cmd.kind = in_range ? CMD_SET_PORT : CMD_NOP;
            MODE_UNUSED:   push_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// File: src/fsq_queue.sv
// -----------------------------------------------------------------------------
// fsq_queue
// Short command FIFO that decouples the classifier from the matcher.
// -----------------------------------------------------------------------------
module fsq_queue
    import fsq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: src/fsq_back.sv
// -----------------------------------------------------------------------------
// fsq_back
// Steering table and matcher: compares a lookup against every entry in
// parallel, then picks the tier and the lowest matching queue.
// -----------------------------------------------------------------------------
`include "flow_steer_tx_queue_select_core_defines.svh"

module fsq_back
    import fsq_pkg::*;
#(
    parameter int NUM_QUEUES = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_vld,
    input  cmd_t     q_cmd,
    output logic     pop,
    fsq_out_if.source out_ch
);

    localparam int IDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // table lanes, one comparator each
    logic [31:0] lane_addr_reg [NUM_QUEUES];
    logic [15:0] lane_port_reg [NUM_QUEUES];

    // read-back copy for write results
    logic [31:0]           addr_mem [NUM_QUEUES];
    logic [15:0]           port_mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] addr_vld_reg;
    logic [NUM_QUEUES-1:0] port_vld_reg;

    logic [IDX_W-1:0]      wr_idx;
    logic [8:0]            q_ext;
    logic [NUM_QUEUES-1:0] hit_exact;
    logic [NUM_QUEUES-1:0] hit_ip;
    logic [NUM_QUEUES-1:0] hit_port;

    // match stage
    logic                  a_vld_reg;
    cmd_kind_t             a_kind_reg;
    logic [NUM_QUEUES-1:0] a_exact_reg;
    logic [NUM_QUEUES-1:0] a_ip_reg;
    logic [NUM_QUEUES-1:0] a_port_reg;
    logic [31:0]           a_addr_reg;
    logic [15:0]           a_pval_reg;
    logic [31:0]           rd_addr_reg;
    logic [15:0]           rd_port_reg;
    logic                  rd_addr_ok_reg;
    logic                  rd_port_ok_reg;

    // result register
    logic                  out_vld_reg;
    match_kind_t           out_kind_reg;
    logic [5:0]            out_queue_reg;
    logic [31:0]           out_addr_reg;
    logic [15:0]           out_port_reg;

    match_kind_t           res_kind;
    logic [IDX_W-1:0]      res_idx;
    logic [8:0]            res_idx_ext;
    logic [31:0]           res_addr;
    logic [15:0]           res_port;

    logic out_free;
    logic a_adv;
    logic a_free;

    function automatic logic [IDX_W-1:0] first_set(input logic [NUM_QUEUES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (v[i])
                r = IDX_W'(i);
        end
        return r;
    endfunction

    assign out_free = !out_vld_reg || out_ch.ready;
    assign a_adv    = a_vld_reg && out_free;
    assign a_free   = !a_vld_reg || a_adv;
    assign pop      = q_vld && a_free;

    assign q_ext  = {3'b000, q_cmd.queue};
    assign wr_idx = q_ext[IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            logic valid_e;
            valid_e      = (lane_addr_reg[i] != '0) || (lane_port_reg[i] != '0);
            hit_exact[i] = valid_e && (lane_addr_reg[i] == q_cmd.addr) &&
                           (lane_port_reg[i] == q_cmd.port);
            hit_ip[i]    = valid_e && (lane_port_reg[i] == '0) &&
                           (lane_addr_reg[i] == q_cmd.addr);
            hit_port[i]  = valid_e && (lane_addr_reg[i] == '0) &&
                           (lane_port_reg[i] == q_cmd.port);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                lane_addr_reg[i] <= '0;
                lane_port_reg[i] <= '0;
            end
            addr_vld_reg <= '0;
            port_vld_reg <= '0;
        end
        else if (pop)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                if (wr_idx == IDX_W'(i))
                begin
                    if (q_cmd.kind == CMD_SET_ADDR)
                    begin
                        lane_addr_reg[i] <= q_cmd.addr;
                        addr_vld_reg[i]  <= 1'b1;
                    end
                    if (q_cmd.kind == CMD_SET_PORT)
                    begin
                        lane_port_reg[i] <= q_cmd.port;
                        port_vld_reg[i]  <= 1'b1;
                    end
                end
            end
        end
    end

    // write one memory, read the other entry of the same queue
    always_ff @(posedge clk)
    begin
        if (pop && (q_cmd.kind == CMD_SET_ADDR))
        begin
            addr_mem[wr_idx] <= q_cmd.addr;
            rd_port_reg      <= port_mem[wr_idx];
        end
        if (pop && (q_cmd.kind == CMD_SET_PORT))
        begin
            port_mem[wr_idx] <= q_cmd.port;
            rd_addr_reg      <= addr_mem[wr_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_kind_reg     <= q_cmd.kind;
            a_exact_reg    <= hit_exact;
            a_ip_reg       <= hit_ip;
            a_port_reg     <= hit_port;
            a_addr_reg     <= q_cmd.addr;
            a_pval_reg     <= q_cmd.port;
            rd_addr_ok_reg <= addr_vld_reg[wr_idx];
            rd_port_ok_reg <= port_vld_reg[wr_idx];
        end
    end

    always_comb
    begin
        res_kind = KIND_NONE;
        res_idx  = '0;
        res_addr = '0;
        res_port = '0;
        unique case (a_kind_reg)
            CMD_LOOKUP:
            begin
                priority if (|a_exact_reg)
                begin
                    res_kind = KIND_EXACT;
                    res_idx  = first_set(a_exact_reg);
                end
                else if (|a_ip_reg)
                begin
                    res_kind = KIND_IP_ONLY;
                    res_idx  = first_set(a_ip_reg);
                end
                else if (|a_port_reg)
                begin
                    res_kind = KIND_PORT_ONLY;
                    res_idx  = first_set(a_port_reg);
                end
                else
                begin
                    res_kind = KIND_NONE;
                end
            end
            CMD_DEV_ERR:  res_kind = KIND_DEV_ERROR;
            CMD_SET_ADDR:
            begin
                res_addr = a_addr_reg;
                res_port = rd_port_ok_reg ? rd_port_reg : '0;
            end
            CMD_SET_PORT:
            begin
                res_addr = rd_addr_ok_reg ? rd_addr_reg : '0;
                res_port = a_pval_reg;
            end
            CMD_NOP:      res_kind = KIND_NONE;
            default:      res_kind = KIND_NONE;
        endcase
    end

    assign res_idx_ext = 9'(res_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                a_vld_reg <= 1'b1;
            else if (a_adv)
                a_vld_reg <= 1'b0;

            if (a_adv)
                out_vld_reg <= 1'b1;
            else if (out_ch.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            out_kind_reg  <= res_kind;
            out_queue_reg <= res_idx_ext[5:0];
            out_addr_reg  <= res_addr;
            out_port_reg  <= res_port;
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.match_kind   = out_kind_reg;
    assign out_ch.chosen_queue = out_queue_reg;
    assign out_ch.stored_addr  = out_addr_reg;
    assign out_ch.stored_port  = out_port_reg;

    `FSQ_ASSERT(a_no_pop_when_blocked, (a_vld_reg && !out_free) |-> !pop, "pop while match stage blocked")
    `FSQ_ASSERT(a_lookup_no_store, (out_vld_reg && (out_kind_reg != KIND_NONE)) |-> ((out_addr_reg == '0) && (out_port_reg == '0)), "lookup result carries stored fields")
    `FSQ_ASSERT(a_lane_written, (pop && (q_cmd.kind == CMD_SET_ADDR)) |=> (lane_addr_reg[$past(wr_idx)] == $past(q_cmd.addr)), "table lane not updated by address write")
    `FSQ_ASSERT(a_queue_zero_on_err, (out_vld_reg && (out_kind_reg == KIND_DEV_ERROR || out_kind_reg == KIND_NONE)) |-> (out_queue_reg == '0), "queue nonzero without a match")
    `FSQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (!out_vld_reg && !a_vld_reg), "pipeline busy in reset")

endmodule

// File: src/flow_steer_tx_queue_select_core.sv
// -----------------------------------------------------------------------------
// flow_steer_tx_queue_select_core
// Transmit queue steering: per-queue destination IP/port table with exact,
// IP-only and port-only match tiers, plus a device error override.
// -----------------------------------------------------------------------------
// channel  | dir | words
// ---------+-----+------------------------------------------------------------
// in_ch    | in  | mode, target_queue, addr_value, port_value, ethertype, l4_protocol
// out_ch   | out | match_kind, chosen_queue, stored_addr, stored_port
// cfg      | in  | cfg_we / cfg_wdata: device_error flag
//
// From the accepting edge a word passes the queue slot, the match stage and
// the result register; one word per cycle sustained while out_ch.ready is high.
// Comparators check a lookup against all NUM_QUEUES lanes at once ahead of the match
// stage; the priority pick over the registered hit vectors sets the cycle time.
// Reset clears the table to zero at once; no clearing pass.
// A stalled output holds the result register, then the match stage, then
// fills the two-entry queue, after which in_ch.ready drops.
// -----------------------------------------------------------------------------
module flow_steer_tx_queue_select_core
    import fsq_pkg::*;
#(
    parameter int NUM_QUEUES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    fsq_in_if.sink    in_ch,
    fsq_out_if.source out_ch,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic not_empty;
    cmd_t pop_cmd;

    fsq_front #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .full      (full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    fsq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_cmd   (pop_cmd)
    );

    fsq_back #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_vld  (not_empty),
        .q_cmd  (pop_cmd),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
